// ===== rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, widths and helpers of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

   localparam int MaxKnots  = 32;
   localparam int MaxDegree = 3;
   localparam int FracBits  = 16;

   localparam int ValW  = FracBits + 1;            // knot, u, basis width
   localparam int AddrW = $clog2(MaxKnots);
   localparam int DiffW = ValW + 1;                // signed left/right terms
   localparam int DsrW  = DiffW;                   // positive divisor width
   localparam int DvdW  = 36;                      // |a| * N + d/2, even
   localparam int SumW  = DvdW + 2;                // saved + signed term

   localparam logic [ValW-1:0] FixOne = ValW'(1) << FracBits;

   localparam logic [1:0] CSR_DEGREE = 2'd0;
   localparam logic [1:0] CSR_KNOTS  = 2'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_EQ_RD, S_EQ_CHK, S_SRCH_RD, S_SRCH_CHK, S_LO_RD, S_LO_CHK,
      S_HI_RD, S_HI_CHK, S_LR_RDL, S_LR_L, S_LR_RDR, S_LR_R, S_REC_MUL,
      S_REC_START, S_REC_WAIT, S_REC_APPLY, S_FINISH
   } state_type;

   // clamp a signed sum to [0, 1.0]
   function automatic logic [ValW-1:0] sat_unit(input logic signed [SumW-1:0] v);
      logic [ValW-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(SumW-ValW){1'b0}}, FixOne})) begin
         res = FixOne;
      end else begin
         res = v[ValW-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/bspline_basis_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_top
// Knot store, span search and Cox-de Boor basis recurrence on one divider.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  req     | req_valid/ready, op, knot, u   | in
//  rsp     | rsp_valid/ready, span, basis   | out
//  csr     | csr_valid/ready, index, data   | in
//
//  A load item is written into the knot store as it is accepted. An evaluate
//  item runs a sequencer around one knot memory read port (a read state, then
//  a check state, per read) and one radix-4 divider (two divisions per
//  recurrence term), p*(p+1)/2 terms. New items are taken only while idle.
//  Reset is synchronous; knots are undefined until written. A pending result
//  in the output register does not block a new item; the sequencer waits at
//  its end only if the previous result has not been taken.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [4:0]                   req_knot_index,
   input  logic [bsp_pkg::ValW-1:0]     req_knot_value,
   input  logic [bsp_pkg::ValW-1:0]     req_eval_u,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [4:0]                   rsp_span_index,
   output logic [bsp_pkg::ValW-1:0]     rsp_basis_0,
   output logic [bsp_pkg::ValW-1:0]     rsp_basis_1,
   output logic [bsp_pkg::ValW-1:0]     rsp_basis_2,
   output logic [bsp_pkg::ValW-1:0]     rsp_basis_3,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [5:0]                   csr_data
);
   import bsp_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic [1:0] degree_ff;
   logic [5:0] kiu_ff;

   // knot memory
   logic [ValW-1:0]  mem [MaxKnots];
   logic [ValW-1:0]  rd_data_ff;
   logic [AddrW-1:0] rd_addr;

   // evaluation state
   logic [ValW-1:0]  u_ff, lo_ff;
   logic [1:0]       deg_ff;
   logic [AddrW-1:0] n_ff, first_ff, count_ff, span_ff;
   logic [1:0]       j_ff, r_ff;
   logic             phase_ff;
   logic [ValW-1:0]  saved_ff;
   logic [ValW-1:0]  nb_ff [4];
   logic signed [DiffW-1:0] lft_ff [1:3];
   logic signed [DiffW-1:0] rgt_ff [1:3];
   logic signed [DvdW:0]    tr_ff;
   logic [DvdW-1:0] dvd_ff;
   logic [DsrW-1:0] dsr_ff;
   logic            neg_ff, dpos_ff;

   // result register
   logic             rsp_valid_ff;
   logic [AddrW-1:0] rsp_span_ff;
   logic [ValW-1:0]  rsp_basis_ff [4];

   logic req_take, load_take, eval_take, rsp_load;
   logic div_start, div_done;
   logic [DvdW-1:0] div_q;

   // derived degree and knot count at accept
   logic [3:0] kmin;
   logic [5:0] kn;
   logic [5:0] n_calc;

   // search step
   logic [AddrW-1:0] step, probe;

   // recurrence datapath
   logic signed [DiffW-1:0] a_sel, rgt_sel, lft_sel;
   logic signed [DiffW:0]   d_sum;
   logic [DiffW-1:0]        abs_a;
   logic [DiffW+ValW-1:0]   prod;
   logic signed [DvdW:0]    term;
   logic signed [SumW-1:0]  acc;
   logic [ValW-1:0]         nb_new, saved_new;
   logic [ValW-1:0]         u_lo;

   assign req_take  = req_valid && req_ready;
   assign load_take = req_take && (req_op == OP_LOAD);
   assign eval_take = req_take && (req_op == OP_EVAL);
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      kmin   = {1'b0, degree_ff, 1'b0} + 4'd2;
      if (kiu_ff < {2'b00, kmin}) begin
         kn = {2'b00, kmin};
      end else if (kiu_ff > 6'(MaxKnots)) begin
         kn = 6'(MaxKnots);
      end else begin
         kn = kiu_ff;
      end
      n_calc = kn - {4'd0, degree_ff} - 6'd2;

      step  = count_ff >> 1;
      probe = first_ff + step;

      rgt_sel = rgt_ff[r_ff + 2'd1];
      lft_sel = lft_ff[j_ff - r_ff];
      a_sel   = phase_ff ? lft_sel : rgt_sel;
      d_sum   = {rgt_sel[DiffW-1], rgt_sel} + {lft_sel[DiffW-1], lft_sel};
      abs_a   = a_sel[DiffW-1] ? DiffW'(-a_sel) : DiffW'(a_sel);
      prod    = abs_a * nb_ff[r_ff];

      if (!dpos_ff) begin
         term = '0;
      end else if (neg_ff) begin
         term = -$signed({1'b0, div_q});
      end else begin
         term = $signed({1'b0, div_q});
      end
      acc       = $signed({{(SumW-ValW){1'b0}}, saved_ff}) + SumW'(tr_ff);
      nb_new    = sat_unit(acc);
      saved_new = sat_unit(SumW'(term));

      u_lo = (u_ff < lo_ff) ? lo_ff : u_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (eval_take) state_in = S_EQ_RD;
         S_EQ_RD:     state_in = S_EQ_CHK;
         S_EQ_CHK:    state_in = (rd_data_ff == u_ff) ? S_LO_RD : S_SRCH_RD;
         S_SRCH_RD:   state_in = S_SRCH_CHK;
         S_SRCH_CHK: begin
            if (rd_data_ff <= u_ff) begin
               state_in = (count_ff - step - AddrW'(1) == '0) ? S_LO_RD : S_SRCH_RD;
            end else begin
               state_in = (step == '0) ? S_LO_RD : S_SRCH_RD;
            end
         end
         S_LO_RD:     state_in = S_LO_CHK;
         S_LO_CHK:    state_in = S_HI_RD;
         S_HI_RD:     state_in = S_HI_CHK;
         S_HI_CHK:    state_in = (deg_ff == 2'd0) ? S_FINISH : S_LR_RDL;
         S_LR_RDL:    state_in = S_LR_L;
         S_LR_L:      state_in = S_LR_RDR;
         S_LR_RDR:    state_in = S_LR_R;
         S_LR_R:      state_in = (j_ff == deg_ff) ? S_REC_MUL : S_LR_RDL;
         S_REC_MUL:   state_in = S_REC_START;
         S_REC_START: state_in = dpos_ff ? S_REC_WAIT : S_REC_APPLY;
         S_REC_WAIT:  if (div_done) state_in = S_REC_APPLY;
         S_REC_APPLY: begin
            if (phase_ff && (r_ff == j_ff - 2'd1) && (j_ff == deg_ff)) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_REC_MUL;
            end
         end
         S_FINISH:    if (rsp_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rd_addr   = '0;
      case (state_ff)
         S_IDLE:      req_ready = 1'b1;
         S_EQ_RD:     rd_addr   = n_ff + AddrW'(1);
         S_SRCH_RD:   rd_addr   = probe;
         S_LO_RD:     rd_addr   = span_ff;
         S_HI_RD:     rd_addr   = span_ff + AddrW'(1);
         S_LR_RDL:    rd_addr   = span_ff + AddrW'(1) - AddrW'(j_ff);
         S_LR_RDR:    rd_addr   = span_ff + AddrW'(j_ff);
         S_REC_START: div_start = dpos_ff;
         default:     rd_addr   = '0;
      endcase
   end

   // knot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (load_take) begin
         mem[req_knot_index] <= req_knot_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= 2'd3;
         kiu_ff       <= 6'd8;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEGREE) begin
               degree_ff <= csr_data[1:0];
            end else if (csr_index == CSR_KNOTS) begin
               kiu_ff <= csr_data;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // evaluation datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (eval_take) begin
               u_ff     <= req_eval_u;
               deg_ff   <= degree_ff;
               n_ff     <= n_calc[AddrW-1:0];
               span_ff  <= n_calc[AddrW-1:0];
               first_ff <= AddrW'(degree_ff);
               count_ff <= AddrW'(n_calc + 6'd1 - {4'd0, degree_ff});
               nb_ff[0] <= FixOne;
               nb_ff[1] <= '0;
               nb_ff[2] <= '0;
               nb_ff[3] <= '0;
               j_ff     <= 2'd1;
            end
         end
         S_SRCH_CHK: begin
            // advance the upper-bound search; fix the span when it closes
            if (rd_data_ff <= u_ff) begin
               first_ff <= probe + AddrW'(1);
               count_ff <= count_ff - step - AddrW'(1);
               span_ff  <= (probe + AddrW'(1) > AddrW'(deg_ff)) ? probe : AddrW'(deg_ff);
            end else begin
               count_ff <= step;
               span_ff  <= (first_ff > AddrW'(deg_ff)) ? first_ff - AddrW'(1)
                                                       : AddrW'(deg_ff);
            end
         end
         S_LO_CHK: lo_ff <= rd_data_ff;
         S_HI_CHK: u_ff  <= (u_lo > rd_data_ff) ? rd_data_ff : u_lo;
         S_LR_L:   lft_ff[j_ff] <= $signed({1'b0, u_ff}) - $signed({1'b0, rd_data_ff});
         S_LR_R: begin
            rgt_ff[j_ff] <= $signed({1'b0, rd_data_ff}) - $signed({1'b0, u_ff});
            if (j_ff == deg_ff) begin
               j_ff     <= 2'd1;
               r_ff     <= 2'd0;
               phase_ff <= 1'b0;
               saved_ff <= '0;
            end else begin
               j_ff <= j_ff + 2'd1;
            end
         end
         S_REC_MUL: begin
            dvd_ff  <= DvdW'(prod) + DvdW'(d_sum[DiffW-1:1]);
            dsr_ff  <= d_sum[DsrW-1:0];
            neg_ff  <= a_sel[DiffW-1];
            dpos_ff <= !d_sum[DiffW] && (d_sum != '0);
         end
         S_REC_APPLY: begin
            if (!phase_ff) begin
               tr_ff    <= term;
               phase_ff <= 1'b1;
            end else begin
               nb_ff[r_ff] <= nb_new;
               phase_ff    <= 1'b0;
               if (r_ff == j_ff - 2'd1) begin
                  nb_ff[j_ff] <= saved_new;
                  j_ff        <= j_ff + 2'd1;
                  r_ff        <= 2'd0;
                  saved_ff    <= '0;
               end else begin
                  r_ff     <= r_ff + 2'd1;
                  saved_ff <= saved_new;
               end
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_span_ff     <= span_ff;
         rsp_basis_ff[0] <= nb_ff[0];
         rsp_basis_ff[1] <= nb_ff[1];
         rsp_basis_ff[2] <= nb_ff[2];
         rsp_basis_ff[3] <= nb_ff[3];
      end
   end

   bsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_ff),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_index = rsp_span_ff;
   assign rsp_basis_0    = rsp_basis_ff[0];
   assign rsp_basis_1    = rsp_basis_ff[1];
   assign rsp_basis_2    = rsp_basis_ff[2];
   assign rsp_basis_3    = rsp_basis_ff[3];

endmodule

// ===== rtl/bsp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module bsp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bsp_pkg::DvdW-1:0]  dividend,
   input  logic [bsp_pkg::DsrW-1:0]  divisor,
   output logic                      done,
   output logic [bsp_pkg::DvdW-1:0]  quotient
);
   import bsp_pkg::*;

   localparam int Steps = DvdW / 2;
   localparam int CntW  = $clog2(Steps + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [DsrW-1:0]   rem_ff, rem_in;
   logic [DsrW-1:0]   dsr_ff, dsr_in;
   logic [DvdW-1:0]   quo_ff, quo_in;
   logic [DsrW:0]     r1, r2, r1s, r2s;
   logic              ge1, ge2;

   always_comb begin
      r1  = {rem_ff, quo_ff[DvdW-1]};
      ge1 = r1 >= {1'b0, dsr_ff};
      r1s = ge1 ? r1 - {1'b0, dsr_ff} : r1;
      r2  = {r1s[DsrW-1:0], quo_ff[DvdW-2]};
      ge2 = r2 >= {1'b0, dsr_ff};
      r2s = ge2 ? r2 - {1'b0, dsr_ff} : r2;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(Steps);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = r2s[DsrW-1:0];
         quo_in = {quo_ff[DvdW-3:0], ge1, ge2};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== verif/bspline_basis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_basis_checker
// Watches the knot, evaluate and register channels of the basis evaluator,
// computes the span and basis values of every evaluate item and compares
// them, in order, with the results that the block hands out.
// ----------------------------------------------------------------------------
module bspline_basis_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_op,
   input  logic [4:0]               req_knot_index,
   input  logic [bsp_pkg::ValW-1:0] req_knot_value,
   input  logic [bsp_pkg::ValW-1:0] req_eval_u,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [4:0]               rsp_span_index,
   input  logic [bsp_pkg::ValW-1:0] rsp_basis_0,
   input  logic [bsp_pkg::ValW-1:0] rsp_basis_1,
   input  logic [bsp_pkg::ValW-1:0] rsp_basis_2,
   input  logic [bsp_pkg::ValW-1:0] rsp_basis_3,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [5:0]               csr_data,
   output int                       error_count,
   output int                       pending_count
);
   import bsp_pkg::*;

   typedef struct packed {
      logic [4:0]      span;
      logic [ValW-1:0] b0;
      logic [ValW-1:0] b1;
      logic [ValW-1:0] b2;
      logic [ValW-1:0] b3;
   } basis_result_type;

   localparam longint One = longint'(1) << FracBits;

   logic [ValW-1:0]  knot_mem [MaxKnots];
   logic [1:0]       degree_reg;
   logic [5:0]       knots_reg;
   basis_result_type basis_queue [$];

   function automatic longint clamp_unit(input longint v);
      if (v < 0) return 0;
      if (v > One) return One;
      return v;
   endfunction

   // round(a * nv / d), halves away from zero
   function automatic longint round_div(input longint a, input longint nv,
                                        input longint d);
      longint mag;
      longint q;
      mag = (a < 0 ? -a : a) * nv;
      q = (mag + d / 2) / d;
      return a < 0 ? -q : q;
   endfunction

   function automatic basis_result_type eval_basis(input logic [ValW-1:0] u_in);
      longint nb [MaxDegree+1];
      longint lft [MaxDegree+1];
      longint rgt [MaxDegree+1];
      longint u, lo, hi, saved, d, cur, tr, tl;
      int deg, kn, n, span, first, count, step, it;
      basis_result_type res;
      deg = degree_reg;
      if (deg > MaxDegree) deg = MaxDegree;
      kn = knots_reg;
      if (kn < 2 * deg + 2) kn = 2 * deg + 2;
      if (kn > MaxKnots) kn = MaxKnots;
      n = kn - deg - 2;
      u = u_in;
      if (u == longint'(knot_mem[n+1])) begin
         span = n;
      end else begin
         first = deg;
         count = n + 1 - deg;
         while (count > 0) begin
            step = count / 2;
            it = first + step;
            if (longint'(knot_mem[it]) <= u) begin
               first = it + 1;
               count -= step + 1;
            end else begin
               count = step;
            end
         end
         span = first - 1;
         if (span < deg) span = deg;
         if (span > n) span = n;
      end
      lo = knot_mem[span];
      hi = knot_mem[span+1];
      if (u < lo) u = lo;
      if (u > hi) u = hi;
      for (int j = 0; j <= MaxDegree; j++) begin
         nb[j] = 0;
         lft[j] = 0;
         rgt[j] = 0;
      end
      nb[0] = One;
      for (int j = 1; j <= deg; j++) begin
         saved = 0;
         lft[j] = u - longint'(knot_mem[span+1-j]);
         rgt[j] = longint'(knot_mem[span+j]) - u;
         for (int r = 0; r < j; r++) begin
            d = rgt[r+1] + lft[j-r];
            cur = nb[r];
            tr = 0;
            tl = 0;
            // where repeated or unsorted knots give no positive divisor, the term is zero
            if (d > 0) begin
               tr = round_div(rgt[r+1], cur, d);
               tl = round_div(lft[j-r], cur, d);
            end
            nb[r] = clamp_unit(saved + tr);
            saved = clamp_unit(tl);
         end
         nb[j] = saved;
      end
      res.span = span[4:0];
      res.b0 = nb[0][ValW-1:0];
      res.b1 = (deg >= 1) ? nb[1][ValW-1:0] : '0;
      res.b2 = (deg >= 2) ? nb[2][ValW-1:0] : '0;
      res.b3 = (deg >= 3) ? nb[3][ValW-1:0] : '0;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [ValW-1:0] exp_v,
                              input logic [ValW-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  exp_v, act_v);
         error_count++;
      end
   endtask

   assign pending_count = basis_queue.size();

   always @(posedge clock) begin
      basis_result_type exp_r;
      if (reset) begin
         degree_reg <= 2'd3;
         knots_reg  <= 6'd8;
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEGREE) degree_reg <= csr_data[1:0];
            else if (csr_index == CSR_KNOTS) knots_reg <= csr_data;
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) knot_mem[req_knot_index] <= req_knot_value;
            else basis_queue.push_back(eval_basis(req_eval_u));
         end
         if (rsp_valid && rsp_ready) begin
            if (basis_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual span %0d",
                        $time, rsp_span_index);
               error_count++;
            end else begin
               exp_r = basis_queue.pop_front();
               check_field("span_index", ValW'(exp_r.span), ValW'(rsp_span_index));
               check_field("basis_0", exp_r.b0, rsp_basis_0);
               check_field("basis_1", exp_r.b1, rsp_basis_1);
               check_field("basis_2", exp_r.b2, rsp_basis_2);
               check_field("basis_3", exp_r.b3, rsp_basis_3);
            end
         end
      end
   end

endmodule

// ===== verif/tb_bspline_basis_evaluator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bspline_basis_evaluator_top
// Drives knot loads, evaluations and register writes into the basis
// evaluator with random idle bursts and lets the checker judge each result.
// ----------------------------------------------------------------------------
module tb_bspline_basis_evaluator_top;
   import bsp_pkg::*;

   localparam int Unit = 1 << FracBits;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic            req_op;
   logic [4:0]      req_knot_index;
   logic [ValW-1:0] req_knot_value;
   logic [ValW-1:0] req_eval_u;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [4:0]      rsp_span_index;
   logic [ValW-1:0] rsp_basis_0;
   logic [ValW-1:0] rsp_basis_1;
   logic [ValW-1:0] rsp_basis_2;
   logic [ValW-1:0] rsp_basis_3;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [5:0]      csr_data;

   int error_count;
   int pending_count;
   int item_count;
   bit quiet;          // no idling in the last stretch of the run
   int cur_degree;
   int cur_knots;
   int knot_copy [MaxKnots];
   int rsp_stall;

   bspline_basis_evaluator_top uut (.*);

   bspline_basis_checker checker_i (.*);

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Result side: ready drops in random bursts of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hold the item until the block takes it; maybe idle before it.
   task automatic send_item(input logic op, input int idx, input int value,
                            input int u);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_knot_index <= idx[4:0];
      req_knot_value <= value[ValW-1:0];
      req_eval_u     <= u[ValW-1:0];
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) knot_copy[idx] = value;
      item_count++;
   endtask

   task automatic load_knot(input int idx, input int value);
      send_item(OP_LOAD, idx, value, $urandom_range(0, Unit));
   endtask

   task automatic eval_at(input int u);
      send_item(OP_EVAL, $urandom_range(0, 31), $urandom_range(0, Unit), u);
   endtask

   // Drain all results, then let the sequencer settle before touching registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[5:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DEGREE) cur_degree = value & 3;
      else if (idx == CSR_KNOTS) cur_knots = value & 63;
   endtask

   // Load all 32 knots. Kinds: 0 clamped sorted, 1 sorted, 2 sorted with
   // repeats, 3 unsorted noise.
   task automatic load_vector(input int kind);
      int vals [$];
      int deg, kn, n;
      deg = cur_degree;
      kn = cur_knots;
      if (kn < 2 * deg + 2) kn = 2 * deg + 2;
      if (kn > MaxKnots) kn = MaxKnots;
      n = kn - deg - 2;
      for (int i = 0; i < MaxKnots; i++) begin
         if (kind == 2) vals.push_back($urandom_range(0, 4) * (Unit / 4));
         else vals.push_back($urandom_range(0, Unit));
      end
      if (kind != 3) vals.sort();
      if (kind == 0) begin
         for (int i = 0; i < MaxKnots; i++) begin
            if (i <= deg) vals[i] = 0;
            else if (i > n) vals[i] = Unit;
         end
         vals.sort();
      end
      for (int i = 0; i < MaxKnots; i++) load_knot(i, vals[i]);
   endtask

   function automatic int pick_u();
      int k;
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 5))
         0: return knot_copy[k];
         1: return (knot_copy[k] > 0) ? knot_copy[k] - 1 : 0;
         2: return (knot_copy[k] < Unit) ? knot_copy[k] + 1 : Unit;
         3: return ($urandom_range(0, 1) != 0) ? 0 : Unit;
         default: return $urandom_range(0, Unit);
      endcase
   endfunction

   initial begin
      int phase_evals;
      quiet = 1'b0;
      item_count = 0;
      cur_degree = 3;
      cur_knots = 8;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_LOAD;
      req_knot_index = '0;
      req_knot_value = '0;
      req_eval_u = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DEGREE;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: clamped cubic, then the edges of u and of the knot vector.
      load_vector(0);
      eval_at(0);
      eval_at(Unit);
      eval_at(knot_copy[cur_knots - cur_degree - 1]);   // knot n+1, the upper end of the domain
      eval_at(knot_copy[4]);
      eval_at(Unit / 2);
      load_knot(31, Unit);
      load_knot(0, 0);
      eval_at(Unit - 1);
      wait_idle();
      // degree zero, knots below the minimum, unused register indexes
      write_csr(CSR_DEGREE, 0);
      write_csr(CSR_KNOTS, 0);
      write_csr(2'd2, 63);
      write_csr(2'd3, 21);
      eval_at(0);
      eval_at(knot_copy[1]);
      eval_at(Unit);
      wait_idle();
      // degree one with the largest knot count, unsorted store
      write_csr(CSR_DEGREE, 1);
      write_csr(CSR_KNOTS, 63);
      load_vector(3);
      eval_at(Unit / 3);
      eval_at(0);
      eval_at(Unit);
      wait_idle();
      write_csr(CSR_DEGREE, 3);
      write_csr(CSR_KNOTS, 32);
      load_vector(2);
      eval_at(knot_copy[10]);
      eval_at(Unit / 4);

      // Random phases: mostly well-formed knot vectors with random content.
      while (item_count < 700) begin
         if (item_count > 620) quiet = 1'b1;
         // pause the sender until everything is back, then reconfigure
         wait_idle();
         case ($urandom_range(0, 3))
            0: write_csr(CSR_DEGREE, 3);
            1: write_csr(CSR_DEGREE, 1);
            default: write_csr(CSR_DEGREE, $urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 4))
            0: write_csr(CSR_KNOTS, 4);
            1: write_csr(CSR_KNOTS, 32);
            2: write_csr(CSR_KNOTS, $urandom_range(0, 63));
            default: write_csr(CSR_KNOTS, $urandom_range(4, 32));
         endcase
         case ($urandom_range(0, 9))
            0: load_vector(3);
            1: load_vector(2);
            2, 3: load_vector(1);
            default: load_vector(0);
         endcase
         phase_evals = $urandom_range(15, 45);
         for (int i = 0; i < phase_evals; i++) begin
            // occasional stray knot rewrite in the middle of a phase
            if ($urandom_range(0, 19) == 0)
               load_knot($urandom_range(0, 31), $urandom_range(0, Unit));
            else
               eval_at(pick_u());
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the sequencer's full latency.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bsp_pkg.sv
rtl/bsp_div.sv
rtl/bspline_basis_evaluator_top.sv
verif/bspline_basis_checker.sv
verif/tb_bspline_basis_evaluator_top.sv
